@@ hw/rtl/sfce_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sfce_pkg;

    // default sizes
    localparam int MAX_RADIUS_DEF  = 15;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_BITS_DEF   = 16;

    // fixed field widths
    localparam int PORT_SAMPLE_W = 16;
    localparam int RADIUS_W      = 4;
    localparam int TAP_REG_W     = 64;
    localparam int TAP_LANE_W    = 16;
    localparam int TAP_LANES     = 4;
    localparam int CFG_IDX_W     = 3;

    // centre tap after reset: 1.0 in q1.15
    localparam logic [TAP_LANE_W-1:0] TAP0_RESET = 16'h8000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS        = 3'd0,
        REG_TAPS_0_TO_3   = 3'd1,
        REG_TAPS_4_TO_7   = 3'd2,
        REG_TAPS_8_TO_11  = 3'd3,
        REG_TAPS_12_TO_15 = 3'd4
    } cfg_reg_t;

endpackage

`default_nettype wire

@@ hw/rtl/symmetric_fir_clamp_edge.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One pass of a separable gaussian blur along a line (row or column). Samples
// arrive one beat per cycle with an end_of_line flag; each result is the
// symmetric fir c0*s[x] + sum ck*(s[x-k] + s[x+k]) with indices past either end
// of the line clamped to the first or last sample, rounded half up from q1.15
// and saturated. The result for position x comes out with sample x+radius; the
// end_of_line beat also starts a flush that emits the remaining positions of the
// line. Throughput is one sample per cycle while a line streams and the result
// side does not hold the pipeline; after each end_of_line beat item_stall stays
// high for radius flush steps, one step per cycle unless the result side holds
// the pipeline, while the window is padded with copies of the last sample. Each
// result passes the step, multiply, partial sum and final sum/saturate stages.
// Both channels keep running independently: a stalled result does not block
// the input until the pipeline is full. The configuration port is always
// ready; write it only while the block is idle.
// Radius values above MAX_RADIUS act as MAX_RADIUS.

module symmetric_fir_clamp_edge
    import sfce_pkg::*;
#(
    parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    // configuration write channel
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [TAP_REG_W-1:0]     cfg_data,

    // sample channel
    input  wire logic                     item_valid,
    output logic                          item_stall,
    input  wire logic [PORT_SAMPLE_W-1:0] sample,
    input  wire logic                     end_of_line,

    // result channel
    output logic                          result_valid,
    input  wire logic                     result_stall,
    output logic [PORT_SAMPLE_W-1:0]      filtered,
    output logic                          line_done,
    output logic                          run_last
);

    // window spans radius taps either side of the centre
    localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
    localparam int NTAP      = MAX_RADIUS + 1;
    localparam int RW        = $clog2(MAX_RADIUS + 1);
    localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
    localparam int PROD_W    = SAMPLE_BITS + COEF_BITS;
    localparam int GRP       = 8;
    localparam int NGRP      = (WIN_DEPTH + GRP - 1) / GRP;
    localparam int GRP_W     = PROD_W + $clog2(GRP);
    localparam int ACC_W     = PROD_W + $clog2(WIN_DEPTH + 1) + 1;
    localparam int FRAC      = COEF_BITS - 1;

    localparam logic [CNT_W-1:0]       CNT_MAX    = CNT_W'(WIN_DEPTH);
    localparam logic [ACC_W-1:0]       ROUND_HALF = ACC_W'(1) << (FRAC - 1);
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [RADIUS_W-1:0]  radius_reg;
    logic [COEF_BITS-1:0] coef_reg [NTAP];
    logic                 cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
        end
        else if (cfg_we && (cfg_index == REG_RADIUS))
        begin
            radius_reg <= cfg_data[RADIUS_W-1:0];
        end
    end

    // one coefficient per distance, taken from its lane of a tap register
    for (genvar k = 0; k < NTAP; k++)
    begin : g_coef
        localparam logic [CFG_IDX_W-1:0] TAP_REG =
            CFG_IDX_W'(REG_TAPS_0_TO_3) + CFG_IDX_W'(k / TAP_LANES);
        localparam int LANE = k % TAP_LANES;
        localparam logic [31:0] RESET_EXT = (k == 0) ? {16'b0, TAP0_RESET} : 32'b0;

        logic [31:0] lane_ext;

        assign lane_ext = {16'b0, cfg_data[LANE*TAP_LANE_W +: TAP_LANE_W]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                coef_reg[k] <= RESET_EXT[COEF_BITS-1:0];
            end
            else if (cfg_we && (cfg_index == TAP_REG))
            begin
                coef_reg[k] <= lane_ext[COEF_BITS-1:0];
            end
        end
    end

    // effective radius
    logic [RW-1:0] r_eff;

    assign r_eff = (radius_reg > RADIUS_W'(MAX_RADIUS)) ? RW'(MAX_RADIUS)
                                                        : radius_reg[RW-1:0];

    // per-position weights: the centre sits at window position r_eff,
    // position p carries the coefficient for distance |p - r_eff|
    logic [COEF_BITS-1:0] w_reg  [WIN_DEPTH];
    logic [COEF_BITS-1:0] w_next [WIN_DEPTH];

    always_comb
    begin
        int r_int;
        int tap_dist;
        r_int = int'(r_eff);
        for (int p = 0; p < WIN_DEPTH; p++)
        begin
            tap_dist = (p >= r_int) ? (p - r_int) : (r_int - p);
            if (tap_dist <= r_int)
            begin
                w_next[p] = coef_reg[RW'(tap_dist)];
            end
            else
            begin
                w_next[p] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
    end

    // ------------------------------------------------------------------
    // pipeline handshake: each stage takes a new beat when it is empty
    // or its content moves on
    // ------------------------------------------------------------------
    logic ev_valid_reg, p_valid_reg, s_valid_reg, out_valid_reg;
    logic ev_ready, p_ready, s_ready, o_ready;

    assign o_ready  = !out_valid_reg || !result_stall;
    assign s_ready  = !s_valid_reg || o_ready;
    assign p_ready  = !p_valid_reg || s_ready;
    assign ev_ready = !ev_valid_reg || p_ready;

    // ------------------------------------------------------------------
    // line state: window shift line, first sample, fill count, flush
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] win_reg [WIN_DEPTH];
    logic [SAMPLE_BITS-1:0] first_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   flushing_reg, flushing_next;
    logic [RW-1:0]          flush_left_reg, flush_left_next;

    logic [31:0]            sample_ext;
    logic [SAMPLE_BITS-1:0] sample_in;
    logic [SAMPLE_BITS-1:0] shift_in;
    logic [CNT_W-1:0]       cnt_inc;
    logic                   step;
    logic                   emit;
    logic                   emit_done;
    logic                   emit_last;

    assign sample_ext = {16'b0, sample};
    assign sample_in  = sample_ext[SAMPLE_BITS-1:0];

    // during a flush the input is held off
    assign item_stall = flushing_reg || !ev_ready;
    assign step       = flushing_reg ? ev_ready : (item_valid && ev_ready);

    // flush steps pad the line with its last sample
    assign shift_in = flushing_reg ? win_reg[0] : sample_in;
    assign cnt_inc  = (count_reg == CNT_MAX) ? count_reg : (count_reg + CNT_W'(1));

    always_comb
    begin
        count_next      = count_reg;
        flushing_next   = flushing_reg;
        flush_left_next = flush_left_reg;
        emit            = 1'b0;
        emit_done       = 1'b0;
        emit_last       = 1'b0;
        if (step)
        begin
            emit       = cnt_inc > CNT_W'(r_eff);
            count_next = cnt_inc;
            if (flushing_reg)
            begin
                flush_left_next = flush_left_reg - RW'(1);
                if (flush_left_reg == RW'(1))
                begin
                    // final position of the line
                    emit_done     = 1'b1;
                    emit_last     = 1'b1;
                    flushing_next = 1'b0;
                    count_next    = '0;
                end
            end
            else if (end_of_line)
            begin
                if (r_eff == '0)
                begin
                    emit_done  = 1'b1;
                    emit_last  = 1'b1;
                    count_next = '0;
                end
                else
                begin
                    flushing_next   = 1'b1;
                    flush_left_next = r_eff;
                end
            end
            else
            begin
                emit_last = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            flushing_reg   <= 1'b0;
            flush_left_reg <= '0;
            first_reg      <= '0;
        end
        else
        begin
            count_reg      <= count_next;
            flushing_reg   <= flushing_next;
            flush_left_reg <= flush_left_next;
            if (step && !flushing_reg && (count_reg == '0))
            begin
                first_reg <= sample_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            win_reg[0] <= shift_in;
            for (int i = 1; i < WIN_DEPTH; i++)
            begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // step stage: a result is due with the centre at position r_eff
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] ev_n_reg;
    logic             ev_done_reg, ev_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            ev_valid_reg <= emit;
        end
        else if (p_ready)
        begin
            ev_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            ev_n_reg    <= cnt_inc;
            ev_done_reg <= emit_done;
            ev_last_reg <= emit_last;
        end
    end

    // ------------------------------------------------------------------
    // multiply stage: positions past the samples held read the first one
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] prod_reg [WIN_DEPTH];
    logic              p_done_reg, p_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (p_ready)
        begin
            p_valid_reg <= ev_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_ready && ev_valid_reg)
        begin
            for (int p = 0; p < WIN_DEPTH; p++)
            begin
                if (CNT_W'(p) < ev_n_reg)
                begin
                    prod_reg[p] <= PROD_W'(win_reg[p]) * PROD_W'(w_reg[p]);
                end
                else
                begin
                    prod_reg[p] <= PROD_W'(first_reg) * PROD_W'(w_reg[p]);
                end
            end
            p_done_reg <= ev_done_reg;
            p_last_reg <= ev_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // partial sums over groups of eight products
    // ------------------------------------------------------------------
    logic [GRP_W-1:0] grp_next [NGRP];
    logic [GRP_W-1:0] grp_reg  [NGRP];
    logic             s_done_reg, s_last_reg;

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < GRP; j++)
            begin
                if (g * GRP + j < WIN_DEPTH)
                begin
                    grp_next[g] = grp_next[g] + GRP_W'(prod_reg[g * GRP + j]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (s_ready)
        begin
            s_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_ready && p_valid_reg)
        begin
            grp_reg    <= grp_next;
            s_done_reg <= p_done_reg;
            s_last_reg <= p_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // final sum, round half up, saturate
    // ------------------------------------------------------------------
    logic [ACC_W-1:0]       acc;
    logic [ACC_W-1:0]       rounded;
    logic [SAMPLE_BITS-1:0] sat;
    logic [SAMPLE_BITS-1:0] out_reg;
    logic                   out_done_reg, out_last_reg;
    logic [31:0]            out_ext;

    always_comb
    begin
        acc = ROUND_HALF;
        for (int g = 0; g < NGRP; g++)
        begin
            acc = acc + ACC_W'(grp_reg[g]);
        end
        rounded = acc >> FRAC;
        sat     = (rounded > ACC_W'(SAMPLE_MAX)) ? SAMPLE_MAX : rounded[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (o_ready)
        begin
            out_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_ready && s_valid_reg)
        begin
            out_reg      <= sat;
            out_done_reg <= s_done_reg;
            out_last_reg <= s_last_reg;
        end
    end

    assign out_ext      = {{(32 - SAMPLE_BITS){1'b0}}, out_reg};
    assign result_valid = out_valid_reg;
    assign filtered     = out_ext[PORT_SAMPLE_W-1:0];
    assign line_done    = out_done_reg;
    assign run_last     = out_last_reg;

endmodule

`default_nettype wire
